>>> sv/i2cm_pkg.sv
package i2cm_pkg;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_START_HI  = 5'd1,
        PH_START_LO  = 5'd2,
        PH_TX_LOW    = 5'd3,
        PH_TX_HIGH   = 5'd4,
        PH_ACK_LOW   = 5'd5,
        PH_ACK_HIGH  = 5'd6,
        PH_RX_LOW    = 5'd7,
        PH_RX_HIGH   = 5'd8,
        PH_NACK_LOW  = 5'd9,
        PH_NACK_HIGH = 5'd10,
        PH_STOP_A    = 5'd11,
        PH_STOP_B    = 5'd12,
        PH_STOP_C    = 5'd13,
        PH_RESTART   = 5'd14
    } phase_t;

    // byte of the frame in flight
    typedef enum logic [1:0] {
        SEL_DEV_WR   = 2'd0,
        SEL_MEM_ADDR = 2'd1,
        SEL_DATA     = 2'd2,
        SEL_DEV_RD   = 2'd3
    } byte_sel_t;

    localparam logic [1:0] CFG_DEV_ADDR    = 2'd0;
    localparam logic [1:0] CFG_HALF_PERIOD = 2'd1;

    localparam logic [6:0] DEV_ADDR_RESET    = 7'd80;
    localparam logic [7:0] HALF_PERIOD_RESET = 8'd5;

    localparam logic       RW_READ       = 1'b1;
    localparam logic       RW_WRITE      = 1'b0;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic [6:0] dev_addr;
        logic [7:0] half_period;
    } cfg_t;

    typedef struct packed {
        logic       ack_missing;
        logic [7:0] rd_data;
        logic       done;
        logic       busy;
        logic       sda_release;
        logic       scl_level;
    } res_t;

endpackage

>>> sv/i2cm_cfg.sv
module i2cm_cfg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [1:0]        wr_index,
    input  logic [7:0]        wr_data,
    output i2cm_pkg::cfg_t    cfg
);
    import i2cm_pkg::*;

    logic [6:0] dev_addr_reg;
    logic [7:0] half_period_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg    <= DEV_ADDR_RESET;
            half_period_reg <= HALF_PERIOD_RESET;
        end else if (wr_en) begin
            if (wr_index == CFG_DEV_ADDR) begin
                dev_addr_reg <= wr_data[6:0];
            end
            if (wr_index == CFG_HALF_PERIOD) begin
                half_period_reg <= wr_data;
            end
        end
    end

    assign cfg.dev_addr    = dev_addr_reg;
    assign cfg.half_period = half_period_reg;

endmodule

>>> sv/i2cm_seq.sv
module i2cm_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  i2cm_pkg::cfg_t    cfg,
    input  logic              go,
    input  logic              func,
    input  logic [7:0]        mem_addr,
    input  logic [7:0]        wr_data,
    input  logic              sda_in,
    output i2cm_pkg::res_t    res
);
    import i2cm_pkg::*;

    phase_t     phase_reg, phase_next;
    byte_sel_t  byte_sel_reg, byte_sel_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] tick_count_reg, tick_count_next;
    logic       op_reg, op_next;
    logic [7:0] addr_reg, addr_next;
    logic [7:0] data_reg, data_next;
    logic       ack_reg, ack_next;
    logic [7:0] read_byte_reg, read_byte_next;

    logic       scl_o, sda_o, busy, done;
    logic [7:0] hp;
    logic [3:0] bit_count_inc;
    logic [7:0] rx_shift;

    function automatic logic [7:0] byte_for(input byte_sel_t sel, input logic [6:0] dev,
                                            input logic [7:0] addr, input logic [7:0] data);
        logic [7:0] b;
        unique case (sel)
            SEL_DEV_WR:   b = {dev, RW_WRITE};
            SEL_MEM_ADDR: b = addr;
            SEL_DATA:     b = data;
            SEL_DEV_RD:   b = {dev, RW_READ};
        endcase
        return b;
    endfunction

    assign hp            = (cfg.half_period == 8'd0) ? 8'd1 : cfg.half_period;
    assign bit_count_inc = bit_count_reg + 4'd1;
    assign rx_shift      = {shift_reg[6:0], sda_in};

    // line levels for the current phase, before the update
    always_comb begin
        scl_o = 1'b1;
        sda_o = 1'b1;
        busy  = 1'b1;
        unique case (phase_reg)
            PH_START_HI: begin scl_o = 1'b1; sda_o = 1'b1; end
            PH_START_LO: begin scl_o = 1'b1; sda_o = 1'b0; end
            PH_TX_LOW:   begin scl_o = 1'b0; sda_o = shift_reg[7]; end
            PH_TX_HIGH:  begin scl_o = 1'b1; sda_o = shift_reg[7]; end
            PH_ACK_LOW, PH_RX_LOW, PH_NACK_LOW, PH_RESTART: begin
                scl_o = 1'b0; sda_o = 1'b1;
            end
            PH_ACK_HIGH, PH_RX_HIGH, PH_NACK_HIGH: begin
                scl_o = 1'b1; sda_o = 1'b1;
            end
            PH_STOP_A:   begin scl_o = 1'b0; sda_o = 1'b0; end
            PH_STOP_B:   begin scl_o = 1'b1; sda_o = 1'b0; end
            PH_STOP_C:   begin scl_o = 1'b1; sda_o = 1'b1; end
            default:     busy = 1'b0;
        endcase
    end

    always_comb begin
        phase_next      = phase_reg;
        byte_sel_next   = byte_sel_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        tick_count_next = tick_count_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        data_next       = data_reg;
        ack_next        = ack_reg;
        read_byte_next  = read_byte_reg;
        done            = 1'b0;

        if (!busy) begin
            phase_next      = PH_IDLE;
            tick_count_next = 8'd0;
            if (go) begin
                op_next        = func;
                addr_next      = mem_addr;
                data_next      = wr_data;
                ack_next       = 1'b0;
                byte_sel_next  = SEL_DEV_WR;
                bit_count_next = 4'd0;
                phase_next     = PH_START_HI;
            end
        end else if (({1'b0, tick_count_reg} + 9'd1) < {1'b0, hp}) begin
            tick_count_next = tick_count_reg + 8'd1;
        end else begin
            tick_count_next = 8'd0;
            unique case (phase_reg)
                PH_START_HI: phase_next = PH_START_LO;
                PH_START_LO: begin
                    // repeated start reloads the address byte with the read bit
                    byte_sel_next  = (byte_sel_reg == SEL_DEV_RD) ? SEL_DEV_RD : SEL_DEV_WR;
                    bit_count_next = 4'd0;
                    shift_next     = byte_for(byte_sel_next, cfg.dev_addr, addr_reg, data_reg);
                    phase_next     = PH_TX_LOW;
                end
                PH_TX_LOW:   phase_next = PH_TX_HIGH;
                PH_TX_HIGH: begin
                    shift_next     = {shift_reg[6:0], 1'b0};
                    bit_count_next = bit_count_inc;
                    phase_next     = (bit_count_inc >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_TX_LOW;
                end
                PH_ACK_LOW:  phase_next = PH_ACK_HIGH;
                PH_ACK_HIGH: begin
                    ack_next = ack_reg | sda_in;
                    unique case (byte_sel_reg)
                        SEL_DEV_WR: begin
                            byte_sel_next  = SEL_MEM_ADDR;
                            bit_count_next = 4'd0;
                            shift_next     = addr_reg;
                            phase_next     = PH_TX_LOW;
                        end
                        SEL_MEM_ADDR: begin
                            if (op_reg) begin
                                byte_sel_next = SEL_DEV_RD;
                                phase_next    = PH_RESTART;
                            end else begin
                                byte_sel_next  = SEL_DATA;
                                bit_count_next = 4'd0;
                                shift_next     = data_reg;
                                phase_next     = PH_TX_LOW;
                            end
                        end
                        SEL_DATA:   phase_next = PH_STOP_A;
                        SEL_DEV_RD: begin
                            bit_count_next = 4'd0;
                            shift_next     = 8'd0;
                            phase_next     = PH_RX_LOW;
                        end
                    endcase
                end
                PH_RX_LOW:   phase_next = PH_RX_HIGH;
                PH_RX_HIGH: begin
                    shift_next     = rx_shift;
                    bit_count_next = bit_count_inc;
                    if (bit_count_inc >= BITS_PER_BYTE) begin
                        read_byte_next = rx_shift;
                        phase_next     = PH_NACK_LOW;
                    end else begin
                        phase_next = PH_RX_LOW;
                    end
                end
                PH_NACK_LOW:  phase_next = PH_NACK_HIGH;
                PH_NACK_HIGH: phase_next = PH_STOP_A;
                PH_STOP_A:    phase_next = PH_STOP_B;
                PH_STOP_B:    phase_next = PH_STOP_C;
                PH_STOP_C: begin
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                PH_RESTART:   phase_next = PH_START_HI;
                default:      phase_next = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            byte_sel_reg   <= SEL_DEV_WR;
            bit_count_reg  <= 4'd0;
            shift_reg      <= 8'd0;
            tick_count_reg <= 8'd0;
            op_reg         <= 1'b0;
            addr_reg       <= 8'd0;
            data_reg       <= 8'd0;
            ack_reg        <= 1'b0;
            read_byte_reg  <= 8'd0;
        end else if (step) begin
            phase_reg      <= phase_next;
            byte_sel_reg   <= byte_sel_next;
            bit_count_reg  <= bit_count_next;
            shift_reg      <= shift_next;
            tick_count_reg <= tick_count_next;
            op_reg         <= op_next;
            addr_reg       <= addr_next;
            data_reg       <= data_next;
            ack_reg        <= ack_next;
            read_byte_reg  <= read_byte_next;
        end
    end

    assign res.scl_level   = scl_o;
    assign res.sda_release = sda_o;
    assign res.busy        = busy;
    assign res.done        = done;
    assign res.rd_data     = read_byte_next;
    assign res.ack_missing = ack_next;

endmodule

>>> sv/i2c_eeprom_byte_master.sv
// I2C byte master for a serial EEPROM. Every input item is one tick of the bus
// sequencer and yields exactly one result item with the SCL/SDA drive levels of
// that tick, busy/done flags, the last read byte and the sticky missing-ack flag.
// Items are taken one per clock; a result appears in the output register the
// cycle after its item is accepted, and s_tready drops only while that register
// holds a result that the sink has not taken. Configuration writes are always
// ready and take effect on the next accepted item.
module i2c_eeprom_byte_master (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] go, [8:1] mem_addr, [16:9] wr_data, [17] sda_in, [23:18] zero
    input  logic [23:0] s_tdata,
    // [0] func
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] scl_level, [1] sda_release, [2] busy_res, [3] done_res,
    // [11:4] rd_data, [12] ack_missing, [15:13] zero
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import i2cm_pkg::*;

    cfg_t cfg;
    res_t res;
    res_t out_reg;
    logic out_valid_reg;
    logic accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    i2cm_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    i2cm_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (accept),
        .cfg      (cfg),
        .go       (s_tdata[0]),
        .func     (s_tuser[0]),
        .mem_addr (s_tdata[8:1]),
        .wr_data  (s_tdata[16:9]),
        .sda_in   (s_tdata[17]),
        .res      (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.ack_missing, out_reg.rd_data, out_reg.done,
                       out_reg.busy, out_reg.sda_release, out_reg.scl_level};

`ifndef SYNTHESIS
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.done |-> out_reg.busy)
        else $error("done without busy");

    a_idle_released: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_reg.busy |-> out_reg.scl_level && out_reg.sda_release)
        else $error("lines driven while idle");

    a_accept_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> out_valid_reg)
        else $error("accepted item produced no result");
`endif

endmodule
